FILE: design/ecr_pkg.sv
// Shared widths, constants and types for the 2D elastic collision response block.
package ecr_pkg;

  localparam int unsigned VEL_W        = 24;
  localparam int unsigned MASS_W       = 16;
  localparam int unsigned NUM_W        = 94;  // dividend / shifted divisor width
  localparam int unsigned QUO_W        = 26;  // quotient bits, covers the cap value
  localparam int unsigned DIV_BITS     = 26;  // one quotient bit per stage
  localparam int unsigned FRONT_STAGES = 10;
  localparam int unsigned LATENCY      = FRONT_STAGES + DIV_BITS + 1;

  localparam logic [QUO_W-1:0] DELTA_CAP = QUO_W'(33554432);

  // Per-component side data that rides along with the division.
  typedef struct packed {
    logic                    degen;
    logic                    cap;
    logic                    neg;
    logic signed [VEL_W-1:0] vel;
  } comp_t;

endpackage

FILE: design/elastic_collision_response_2d.sv
// An accepted input word passes the front pipeline, the divider stages and an output register to its result word.
// Throughput: one word per cycle while the output is not stalled; the 26-stage divider per component sets the depth.
// A stall on the output holds the whole pipeline; no word is lost or repeated.
// Reset clears the valid bits only; the datapath needs no reset.
// Top level: two-body elastic collision response in the plane.
module elastic_collision_response_2d (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ecr_pkg::VEL_W-1:0]     pos_a_x_i,
  input  logic [ecr_pkg::VEL_W-1:0]     pos_a_y_i,
  input  logic [ecr_pkg::VEL_W-1:0]     pos_b_x_i,
  input  logic [ecr_pkg::VEL_W-1:0]     pos_b_y_i,
  input  logic [ecr_pkg::VEL_W-1:0]     vel_a_x_i,
  input  logic [ecr_pkg::VEL_W-1:0]     vel_a_y_i,
  input  logic [ecr_pkg::VEL_W-1:0]     vel_b_x_i,
  input  logic [ecr_pkg::VEL_W-1:0]     vel_b_y_i,
  input  logic [ecr_pkg::MASS_W-1:0]    mass_a_i,
  input  logic [ecr_pkg::MASS_W-1:0]    mass_b_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ecr_pkg::VEL_W-1:0]     new_vel_a_x_o,
  output logic [ecr_pkg::VEL_W-1:0]     new_vel_a_y_o,
  output logic [ecr_pkg::VEL_W-1:0]     new_vel_b_x_o,
  output logic [ecr_pkg::VEL_W-1:0]     new_vel_b_y_o,
  output logic                          degenerate_o
);
  import ecr_pkg::*;

  localparam logic signed [26:0] SAT_MAX = 27'sd8388607;
  localparam logic signed [26:0] SAT_MIN = -27'sd8388608;

  logic [LATENCY-1:0] vld_q;
  logic               en;

  logic [NUM_W-1:0]   num [4];
  logic [NUM_W-1:0]   den;
  comp_t              tag_f [4];
  logic [QUO_W-1:0]   quo [4];
  comp_t              tag_d [4];

  logic [VEL_W-1:0]   res_d [4];
  logic [VEL_W-1:0]   res_q [4];
  logic               deg_q;

  assign en         = ~(vld_q[LATENCY-1] & out_stall_i);
  assign in_stall_o = ~en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LATENCY-2:0], in_valid_i};
    end
  end

  ecr_front u_front (
    .clk_i     (clk_i),
    .en_i      (en),
    .pos_a_x_i (pos_a_x_i),
    .pos_a_y_i (pos_a_y_i),
    .pos_b_x_i (pos_b_x_i),
    .pos_b_y_i (pos_b_y_i),
    .vel_a_x_i (vel_a_x_i),
    .vel_a_y_i (vel_a_y_i),
    .vel_b_x_i (vel_b_x_i),
    .vel_b_y_i (vel_b_y_i),
    .mass_a_i  (mass_a_i),
    .mass_b_i  (mass_b_i),
    .num_o     (num),
    .den_o     (den),
    .tag_o     (tag_f)
  );

  for (genvar c = 0; c < 4; c++) begin : g_comp
    logic [QUO_W-1:0]  qv;
    logic signed [26:0] base, delta, sum;

    ecr_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num[c]),
      .den_i (den),
      .tag_i (tag_f[c]),
      .quo_o (quo[c]),
      .tag_o (tag_d[c])
    );

    assign qv    = tag_d[c].cap ? DELTA_CAP : quo[c];
    assign base  = {{3{tag_d[c].vel[VEL_W-1]}}, tag_d[c].vel};
    assign delta = {1'b0, qv};
    assign sum   = tag_d[c].neg ? base - delta : base + delta;

    always_comb begin
      if (tag_d[c].degen) begin
        res_d[c] = tag_d[c].vel;
      end else if (sum > SAT_MAX) begin
        res_d[c] = SAT_MAX[VEL_W-1:0];
      end else if (sum < SAT_MIN) begin
        res_d[c] = SAT_MIN[VEL_W-1:0];
      end else begin
        res_d[c] = sum[VEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      deg_q <= tag_d[0].degen;
    end
  end

  assign out_valid_o   = vld_q[LATENCY-1];
  assign new_vel_a_x_o = res_q[0];
  assign new_vel_a_y_o = res_q[1];
  assign new_vel_b_x_o = res_q[2];
  assign new_vel_b_y_o = res_q[3];
  assign degenerate_o  = deg_q;

endmodule

FILE: design/ecr_front.sv
// Front pipeline: offsets, dot products, denominator and numerators, cap test.
module ecr_front (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [ecr_pkg::VEL_W-1:0]       pos_a_x_i,
  input  logic [ecr_pkg::VEL_W-1:0]       pos_a_y_i,
  input  logic [ecr_pkg::VEL_W-1:0]       pos_b_x_i,
  input  logic [ecr_pkg::VEL_W-1:0]       pos_b_y_i,
  input  logic [ecr_pkg::VEL_W-1:0]       vel_a_x_i,
  input  logic [ecr_pkg::VEL_W-1:0]       vel_a_y_i,
  input  logic [ecr_pkg::VEL_W-1:0]       vel_b_x_i,
  input  logic [ecr_pkg::VEL_W-1:0]       vel_b_y_i,
  input  logic [ecr_pkg::MASS_W-1:0]      mass_a_i,
  input  logic [ecr_pkg::MASS_W-1:0]      mass_b_i,
  output logic [ecr_pkg::NUM_W-1:0]       num_o [4],
  output logic [ecr_pkg::NUM_W-1:0]       den_o,
  output ecr_pkg::comp_t                  tag_o [4]
);
  import ecr_pkg::*;

  // component order: a.x, a.y, b.x, b.y
  typedef logic signed [VEL_W-1:0] vel4_t [4];

  // stage 1
  logic signed [24:0] dx1_q, dy1_q, dvx1_q, dvy1_q;
  logic [16:0]        ms1_q, wa1_q, wb1_q;
  vel4_t              vel1_q;
  // stage 2
  logic [49:0]        xx2_q, yy2_q;
  logic signed [49:0] tx2_q, ty2_q;
  logic [24:0]        adx2_q, ady2_q;
  logic               sx2_q, sy2_q;
  logic [16:0]        ms2_q, wa2_q, wb2_q;
  vel4_t              vel2_q;
  // stage 3
  logic [49:0]        d23_q;
  logic signed [50:0] t3_q;
  logic [24:0]        adx3_q, ady3_q;
  logic               sx3_q, sy3_q;
  logic [16:0]        ms3_q, wa3_q, wb3_q;
  vel4_t              vel3_q;
  // stage 4
  logic [49:0]        at4_q;
  logic               nx4_q, ny4_q, deg4_q;
  logic [41:0]        dlo4_q, dhi4_q;
  logic [24:0]        adx4_q, ady4_q;
  logic [16:0]        wa4_q, wb4_q;
  vel4_t              vel4_q;
  // stage 5
  logic [66:0]        d5_q;
  logic [49:0]        pxl5_q, pxh5_q, pyl5_q, pyh5_q;
  logic               nx5_q, ny5_q, deg5_q;
  logic [16:0]        wa5_q, wb5_q;
  vel4_t              vel5_q;
  // stage 6
  logic [66:0]        d6_q;
  logic [74:0]        px6_q, py6_q;
  logic               nx6_q, ny6_q, deg6_q;
  logic [16:0]        wa6_q, wb6_q;
  vel4_t              vel6_q;
  // stage 7
  logic [66:0]        d7_q;
  logic [41:0]        pp7_q [4][3];
  logic               nx7_q, ny7_q, deg7_q;
  vel4_t              vel7_q;
  // stage 8
  logic [66:0]        d8_q;
  logic [NUM_W-1:0]   n8_q [4];
  logic [NUM_W-1:0]   thr8_q;
  logic               nx8_q, ny8_q, deg8_q;
  vel4_t              vel8_q;
  // stage 9
  logic [NUM_W-1:0]   num9_q [4];
  logic [NUM_W-1:0]   den9_q, thr9_q;
  logic               nx9_q, ny9_q, deg9_q;
  vel4_t              vel9_q;
  // stage 10
  logic [NUM_W-1:0]   num10_q [4];
  logic [NUM_W-1:0]   den10_q;
  comp_t              tag10_q [4];

  logic [24:0] adx_d, ady_d;
  logic [50:0] tmag_d;

  assign adx_d  = dx1_q[24] ? 25'(-dx1_q) : 25'(dx1_q);
  assign ady_d  = dy1_q[24] ? 25'(-dy1_q) : 25'(dy1_q);
  assign tmag_d = t3_q[50] ? 51'(-t3_q) : 51'(t3_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: offsets, mass sum and doubled masses
      dx1_q  <= $signed({pos_b_x_i[23], pos_b_x_i}) - $signed({pos_a_x_i[23], pos_a_x_i});
      dy1_q  <= $signed({pos_b_y_i[23], pos_b_y_i}) - $signed({pos_a_y_i[23], pos_a_y_i});
      dvx1_q <= $signed({vel_b_x_i[23], vel_b_x_i}) - $signed({vel_a_x_i[23], vel_a_x_i});
      dvy1_q <= $signed({vel_b_y_i[23], vel_b_y_i}) - $signed({vel_a_y_i[23], vel_a_y_i});
      ms1_q  <= {1'b0, mass_a_i} + {1'b0, mass_b_i};
      wa1_q  <= {mass_a_i, 1'b0};
      wb1_q  <= {mass_b_i, 1'b0};
      vel1_q[0] <= vel_a_x_i;
      vel1_q[1] <= vel_a_y_i;
      vel1_q[2] <= vel_b_x_i;
      vel1_q[3] <= vel_b_y_i;

      // stage 2: squares and dot-product terms
      xx2_q  <= adx_d * adx_d;
      yy2_q  <= ady_d * ady_d;
      tx2_q  <= dvx1_q * dx1_q;
      ty2_q  <= dvy1_q * dy1_q;
      adx2_q <= adx_d;
      ady2_q <= ady_d;
      sx2_q  <= dx1_q[24];
      sy2_q  <= dy1_q[24];
      ms2_q  <= ms1_q;
      wa2_q  <= wa1_q;
      wb2_q  <= wb1_q;
      vel2_q <= vel1_q;

      // stage 3: D2 and t
      d23_q  <= xx2_q + yy2_q;
      t3_q   <= $signed({tx2_q[49], tx2_q}) + $signed({ty2_q[49], ty2_q});
      adx3_q <= adx2_q;
      ady3_q <= ady2_q;
      sx3_q  <= sx2_q;
      sy3_q  <= sy2_q;
      ms3_q  <= ms2_q;
      wa3_q  <= wa2_q;
      wb3_q  <= wb2_q;
      vel3_q <= vel2_q;

      // stage 4: |t|, direction signs, degenerate flag, denominator halves
      at4_q  <= tmag_d[49:0];
      nx4_q  <= t3_q[50] ^ sx3_q;
      ny4_q  <= t3_q[50] ^ sy3_q;
      deg4_q <= (d23_q == '0) || (ms3_q == '0);
      dlo4_q <= ms3_q * d23_q[24:0];
      dhi4_q <= ms3_q * d23_q[49:25];
      adx4_q <= adx3_q;
      ady4_q <= ady3_q;
      wa4_q  <= wa3_q;
      wb4_q  <= wb3_q;
      vel4_q <= vel3_q;

      // stage 5: denominator, |t|*|d| halves
      d5_q   <= {25'd0, dlo4_q} + {dhi4_q, 25'd0};
      pxl5_q <= at4_q[24:0] * adx4_q;
      pxh5_q <= at4_q[49:25] * adx4_q;
      pyl5_q <= at4_q[24:0] * ady4_q;
      pyh5_q <= at4_q[49:25] * ady4_q;
      nx5_q  <= nx4_q;
      ny5_q  <= ny4_q;
      deg5_q <= deg4_q;
      wa5_q  <= wa4_q;
      wb5_q  <= wb4_q;
      vel5_q <= vel4_q;

      // stage 6
      d6_q   <= d5_q;
      px6_q  <= {25'd0, pxl5_q} + {pxh5_q, 25'd0};
      py6_q  <= {25'd0, pyl5_q} + {pyh5_q, 25'd0};
      nx6_q  <= nx5_q;
      ny6_q  <= ny5_q;
      deg6_q <= deg5_q;
      wa6_q  <= wa5_q;
      wb6_q  <= wb5_q;
      vel6_q <= vel5_q;

      // stage 7: mass weight, three partial products each
      for (int p = 0; p < 3; p++) begin
        pp7_q[0][p] <= px6_q[25*p +: 25] * wb6_q;
        pp7_q[1][p] <= py6_q[25*p +: 25] * wb6_q;
        pp7_q[2][p] <= px6_q[25*p +: 25] * wa6_q;
        pp7_q[3][p] <= py6_q[25*p +: 25] * wa6_q;
      end
      d7_q   <= d6_q;
      nx7_q  <= nx6_q;
      ny7_q  <= ny6_q;
      deg7_q <= deg6_q;
      vel7_q <= vel6_q;

      // stage 8: numerators; cap threshold is 2d * (2^25 + 1)
      for (int c = 0; c < 4; c++) begin
        n8_q[c] <= NUM_W'(pp7_q[c][0]) + (NUM_W'(pp7_q[c][1]) << 25)
                 + (NUM_W'(pp7_q[c][2]) << 50);
      end
      thr8_q <= (NUM_W'(d7_q) << 26) + (NUM_W'(d7_q) << 1);
      d8_q   <= d7_q;
      nx8_q  <= nx7_q;
      ny8_q  <= ny7_q;
      deg8_q <= deg7_q;
      vel8_q <= vel7_q;

      // stage 9: rounding offset, 2n + d over 2d
      for (int c = 0; c < 4; c++) begin
        num9_q[c] <= (n8_q[c] << 1) + NUM_W'(d8_q);
      end
      den9_q <= NUM_W'(d8_q) << 1;
      thr9_q <= thr8_q;
      nx9_q  <= nx8_q;
      ny9_q  <= ny8_q;
      deg9_q <= deg8_q;
      vel9_q <= vel8_q;

      // stage 10: cap test and side tags
      for (int c = 0; c < 4; c++) begin
        num10_q[c]       <= num9_q[c];
        tag10_q[c].cap   <= num9_q[c] >= thr9_q;
        tag10_q[c].degen <= deg9_q;
        tag10_q[c].vel   <= vel9_q[c];
      end
      tag10_q[0].neg <= nx9_q;
      tag10_q[1].neg <= ny9_q;
      tag10_q[2].neg <= ~nx9_q;
      tag10_q[3].neg <= ~ny9_q;
      den10_q <= den9_q;
    end
  end

  assign num_o = num10_q;
  assign den_o = den10_q;
  assign tag_o = tag10_q;

endmodule

FILE: design/ecr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
module ecr_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ecr_pkg::NUM_W-1:0]   num_i,
  input  logic [ecr_pkg::NUM_W-1:0]   den_i,
  input  ecr_pkg::comp_t              tag_i,
  output logic [ecr_pkg::QUO_W-1:0]   quo_o,
  output ecr_pkg::comp_t              tag_o
);
  import ecr_pkg::*;

  logic [NUM_W-1:0] rem_q [DIV_BITS];
  logic [NUM_W-1:0] den_q [DIV_BITS];
  logic [QUO_W-1:0] quo_q [DIV_BITS];
  comp_t            tag_q [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
    logic [NUM_W-1:0] rem_in, den_in, sub_v;
    logic [QUO_W-1:0] quo_in;
    comp_t            tag_in;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    // divisor aligned to quotient bit DIV_BITS-1-k
    assign sub_v = den_in << (DIV_BITS - 1 - k);
    assign ge    = rem_in >= sub_v;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? rem_in - sub_v : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= quo_in | (QUO_W'(ge) << (DIV_BITS - 1 - k));
        tag_q[k] <= tag_in;
      end
    end
  end

  assign quo_o = quo_q[DIV_BITS-1];
  assign tag_o = tag_q[DIV_BITS-1];

endmodule
